[design/ultrasound_obstacle_encoder_assert.svh]
// ---------------------------------------------------------------------------
// ultrasound obstacle encoder assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ULTRASOUND_OBSTACLE_ENCODER_ASSERT_SVH
`define ULTRASOUND_OBSTACLE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define UOE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UOE_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UOE_ASSERT(lbl, clk, rstn, prop, msg)
`define UOE_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

[design/uoe_pkg.sv]
// ---------------------------------------------------------------------------
// uoe_pkg
// shared types and constants of the ultrasound obstacle encoder
// ---------------------------------------------------------------------------
package uoe_pkg;

  localparam int NUM_SENSORS = 6;

  typedef logic [9:0] dist_t;
  typedef logic [7:0] speed_t;
  typedef logic [7:0] code_t;
  typedef logic [4:0] margin_t;
  typedef logic [5:0] half_t;

  localparam dist_t   THRESH_RESET = 10'd200;
  localparam half_t   HALF_MAX     = 6'd63;
  localparam margin_t SPEED_MARGIN = 5'd2;

endpackage

[design/uoe_if.sv]
// ---------------------------------------------------------------------------
// uoe channel interfaces
// valid/ready channels for sample items and code items
// ---------------------------------------------------------------------------
interface uoe_in_if import uoe_pkg::*; ();
  logic   valid;
  logic   ready;
  dist_t  dist_side_left;
  dist_t  dist_front_side_left;
  dist_t  dist_front_left;
  dist_t  dist_front_right;
  dist_t  dist_front_side_right;
  dist_t  dist_side_right;
  speed_t car_speed;

  modport source (
    output valid, dist_side_left, dist_front_side_left, dist_front_left,
           dist_front_right, dist_front_side_right, dist_side_right, car_speed,
    input  ready
  );
  modport sink (
    input  valid, dist_side_left, dist_front_side_left, dist_front_left,
           dist_front_right, dist_front_side_right, dist_side_right, car_speed,
    output ready
  );
endinterface

interface uoe_out_if import uoe_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t code_side_left;
  code_t code_front_side_left;
  code_t code_front_left;
  code_t code_front_right;
  code_t code_front_side_right;
  code_t code_side_right;

  modport source (
    output valid, code_side_left, code_front_side_left, code_front_left,
           code_front_right, code_front_side_right, code_side_right,
    input  ready
  );
  modport sink (
    input  valid, code_side_left, code_front_side_left, code_front_left,
           code_front_right, code_front_side_right, code_side_right,
    output ready
  );
endinterface

[design/ultrasound_obstacle_encoder.sv]
// ---------------------------------------------------------------------------
// ultrasound_obstacle_encoder
// encodes six ultrasound distances into per-sensor obstacle status codes
// ---------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  in_ch    in   valid/ready  six 10-bit distances, 8-bit car speed
//  out_ch   out  valid/ready  six 8-bit status codes
//  cfg_*    in   cfg_we       10-bit detection threshold
//
//  one item per cycle unless out_ch stalls; input then result register
//  input register feeds six lanes and one 8x8 reciprocal multiply
//  previous distances update as an item moves into the result register
//  reset clears valids, previous distances and sets threshold to 200
//  a stalled result leaves room for one more item in the input register
// ---------------------------------------------------------------------------
`include "ultrasound_obstacle_encoder_assert.svh"

module ultrasound_obstacle_encoder import uoe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  uoe_in_if.sink       in_ch,
  uoe_out_if.source    out_ch,
  input  logic         cfg_we,
  input  dist_t        cfg_wdata
);

  dist_t   thresh_r;
  logic    s1_v_r, s1_v_nxt;
  dist_t   dist_s1_r [NUM_SENSORS];
  speed_t  speed_s1_r;
  dist_t   prev_r [NUM_SENSORS];
  code_t   code_r [NUM_SENSORS];
  code_t   code_nxt [NUM_SENSORS];
  logic    out_valid_r, out_valid_nxt;
  logic    in_fire, s2_rdy, adv;
  logic [15:0] speed_prod;
  margin_t margin;
  logic [NUM_SENSORS-1:0] lost;
  logic [NUM_SENSORS-1:0] nbr_lost;

  assign s2_rdy      = !out_valid_r || out_ch.ready;
  assign adv         = s1_v_r && s2_rdy;
  assign in_ch.ready = !s1_v_r || s2_rdy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // speed / 10 as (speed * 205) >> 11, exact over the 8-bit range
  assign speed_prod = {8'd0, speed_s1_r} * 16'd205;
  assign margin     = speed_prod[15:11] + SPEED_MARGIN;

  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    if (i == 0) begin : g_first
      assign nbr_lost[i] = lost[i+1];
    end else if (i == NUM_SENSORS - 1) begin : g_last
      assign nbr_lost[i] = lost[i-1];
    end else begin : g_mid
      assign nbr_lost[i] = lost[i-1] || lost[i+1];
    end

    uoe_lane u_lane (
      .cur      (dist_s1_r[i]),
      .prev     (prev_r[i]),
      .thresh   (thresh_r),
      .margin   (margin),
      .nbr_lost (nbr_lost[i]),
      .lost     (lost[i]),
      .code     (code_nxt[i])
    );
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_SENSORS; k++) begin
        prev_r[k] <= '0;
      end
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (adv) begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
          prev_r[k] <= dist_s1_r[k];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dist_s1_r[0] <= in_ch.dist_side_left;
      dist_s1_r[1] <= in_ch.dist_front_side_left;
      dist_s1_r[2] <= in_ch.dist_front_left;
      dist_s1_r[3] <= in_ch.dist_front_right;
      dist_s1_r[4] <= in_ch.dist_front_side_right;
      dist_s1_r[5] <= in_ch.dist_side_right;
      speed_s1_r   <= in_ch.car_speed;
    end
    if (adv) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        code_r[k] <= code_nxt[k];
      end
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.code_side_left        = code_r[0];
  assign out_ch.code_front_side_left  = code_r[1];
  assign out_ch.code_front_left       = code_r[2];
  assign out_ch.code_front_right      = code_r[3];
  assign out_ch.code_front_side_right = code_r[4];
  assign out_ch.code_side_right       = code_r[5];

  `UOE_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_valid_r && !s1_v_r, "pipeline not empty after reset")
  `UOE_ASSERT(a_stall_cause, clk, rst_n, !in_ch.ready |-> s1_v_r && out_valid_r && !out_ch.ready, "input stalled without a full pipeline")
  `UOE_ASSERT(a_prev_update, clk, rst_n, adv |=> prev_r[0] == $past(dist_s1_r[0]) && prev_r[5] == $past(dist_s1_r[5]), "previous distances not updated")
  `UOE_ASSERT(a_result_load, clk, rst_n, adv |=> out_valid_r, "processed item did not reach the result register")

endmodule

[design/uoe_lane.sv]
// ---------------------------------------------------------------------------
// uoe_lane
// per-sensor detect, half-distance saturation, movement test and lost-obstacle flag
// ---------------------------------------------------------------------------
module uoe_lane import uoe_pkg::*; (
  input  dist_t   cur,
  input  dist_t   prev,
  input  dist_t   thresh,
  input  margin_t margin,
  input  logic    nbr_lost,
  output logic    lost,
  output code_t   code
);

  logic [8:0] half_full;
  half_t      half_sat;
  dist_t      diff;
  logic       detected;
  logic       moving;

  always_comb begin
    half_full = cur[9:1];
    half_sat  = (half_full[8:6] != 3'd0) ? HALF_MAX : half_full[5:0];
    diff      = (cur >= prev) ? (cur - prev) : (prev - cur);
    detected  = cur < thresh;
    moving    = (diff > {5'd0, margin}) || nbr_lost;
    lost      = (prev < thresh) && (cur > thresh);
    code      = detected ? {half_sat, moving, 1'b1} : '0;
  end

endmodule
